@@ hdl/gspd_pkg.sv @@
`timescale 1ns / 1ps

package gspd_pkg;

    // Fixed field widths
    localparam int GAIN_W    = 16;
    localparam int FRAC_W    = 8;
    localparam int BAND_W    = 16;
    localparam int SPEED_W   = 10;
    localparam int VEL_W     = 11;
    localparam int PHASE_W   = 2;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    // Velocity scaling: gains in 1/16, error in 1/2048 rotation
    localparam int QSHIFT    = 15;
    localparam int QSAT      = 1024;
    localparam int DEAD_ZONE = 20;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        PH_INIT  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_TRACK = 2'd2
    } phase_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INIT_KP        = 3'd0,
        REG_INIT_KI        = 3'd1,
        REG_INIT_KD        = 3'd2,
        REG_ACCEL_KI       = 3'd3,
        REG_TRACK_KP       = 3'd4,
        REG_TRACK_KD       = 3'd5,
        REG_ACCEL_FRACTION = 3'd6,
        REG_SETTLE_BAND    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] init_kp;
        logic [GAIN_W-1:0] init_ki;
        logic [GAIN_W-1:0] init_kd;
        logic [GAIN_W-1:0] accel_ki;
        logic [GAIN_W-1:0] track_kp;
        logic [GAIN_W-1:0] track_kd;
        logic [FRAC_W-1:0] accel_fraction;
        logic [BAND_W-1:0] settle_band;
    } cfg_t;

    // Per-word control that rides along the pipe
    typedef struct packed {
        logic               start;
        logic [SPEED_W-1:0] speed;
        logic               done;
        phase_t             phase;
    } ctl_t;

endpackage

@@ hdl/gspd_if.sv @@
`timescale 1ns / 1ps

interface gspd_req_if #(
    parameter int POS_WIDTH = 32
) ();
    import gspd_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic signed [POS_WIDTH-1:0] target;
    logic [SPEED_W-1:0]          speed_limit;
    logic signed [POS_WIDTH-1:0] left_position;
    logic signed [POS_WIDTH-1:0] right_position;

    modport source (
        output valid, cmd, target, speed_limit, left_position, right_position,
        input  ready
    );
    modport sink (
        input  valid, cmd, target, speed_limit, left_position, right_position,
        output ready
    );
endinterface

interface gspd_rsp_if ();
    import gspd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] drive_velocity;
    logic                    done_res;
    logic [PHASE_W-1:0]      phase;

    modport source (
        output valid, drive_velocity, done_res, phase,
        input  ready
    );
    modport sink (
        input  valid, drive_velocity, done_res, phase,
        output ready
    );
endinterface

@@ hdl/gspd_cfg_regs.sv @@
`timescale 1ns / 1ps

module gspd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gspd_pkg::ADDR_W-1:0] paddr,
    input  logic [gspd_pkg::DATA_W-1:0] pwdata,
    output logic [gspd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output gspd_pkg::cfg_t              cfg
);
    import gspd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_kp        <= GAIN_W'(4000);
            cfg_reg.init_ki        <= GAIN_W'(64);
            cfg_reg.init_kd        <= GAIN_W'(1600);
            cfg_reg.accel_ki       <= GAIN_W'(40);
            cfg_reg.track_kp       <= GAIN_W'(3040);
            cfg_reg.track_kd       <= GAIN_W'(1600);
            cfg_reg.accel_fraction <= FRAC_W'(192);
            cfg_reg.settle_band    <= BAND_W'(102);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_INIT_KP:        cfg_reg.init_kp        <= pwdata[GAIN_W-1:0];
                REG_INIT_KI:        cfg_reg.init_ki        <= pwdata[GAIN_W-1:0];
                REG_INIT_KD:        cfg_reg.init_kd        <= pwdata[GAIN_W-1:0];
                REG_ACCEL_KI:       cfg_reg.accel_ki       <= pwdata[GAIN_W-1:0];
                REG_TRACK_KP:       cfg_reg.track_kp       <= pwdata[GAIN_W-1:0];
                REG_TRACK_KD:       cfg_reg.track_kd       <= pwdata[GAIN_W-1:0];
                REG_ACCEL_FRACTION: cfg_reg.accel_fraction <= pwdata[FRAC_W-1:0];
                REG_SETTLE_BAND:    cfg_reg.settle_band    <= pwdata[BAND_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_INIT_KP:        prdata = DATA_W'(cfg_reg.init_kp);
            REG_INIT_KI:        prdata = DATA_W'(cfg_reg.init_ki);
            REG_INIT_KD:        prdata = DATA_W'(cfg_reg.init_kd);
            REG_ACCEL_KI:       prdata = DATA_W'(cfg_reg.accel_ki);
            REG_TRACK_KP:       prdata = DATA_W'(cfg_reg.track_kp);
            REG_TRACK_KD:       prdata = DATA_W'(cfg_reg.track_kd);
            REG_ACCEL_FRACTION: prdata = DATA_W'(cfg_reg.accel_fraction);
            REG_SETTLE_BAND:    prdata = DATA_W'(cfg_reg.settle_band);
            default:            prdata = '0;
        endcase
    end

endmodule

@@ hdl/gspd_loop.sv @@
`timescale 1ns / 1ps

module gspd_loop #(
    parameter int POS_WIDTH   = 32,
    parameter int INTEG_WIDTH = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gspd_pkg::cfg_t                cfg,
    gspd_req_if.sink                      req,
    output logic                          s1_valid,
    input  logic                          s1_ready,
    output gspd_pkg::ctl_t                s1_ctl,
    output logic signed [POS_WIDTH+1:0]   s1_err,
    output logic signed [POS_WIDTH+2:0]   s1_deriv,
    output logic signed [INTEG_WIDTH-1:0] s1_integ,
    output logic [gspd_pkg::GAIN_W-1:0]   s1_kp,
    output logic [gspd_pkg::GAIN_W-1:0]   s1_ki,
    output logic [gspd_pkg::GAIN_W-1:0]   s1_kd
);
    import gspd_pkg::*;

    localparam int ERR_W = POS_WIDTH + 2;
    localparam int DER_W = POS_WIDTH + 3;
    localparam int SAT_W = ((INTEG_WIDTH > ERR_W) ? INTEG_WIDTH : ERR_W) + 1;
    localparam int CMP_W = ERR_W + FRAC_W;
    localparam logic signed [SAT_W-1:0] IMAX =
        (SAT_W'(1) << (INTEG_WIDTH - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] IMIN = ~IMAX;

    // input register
    logic                        s0_valid_reg;
    logic                        s0_cmd_reg;
    logic signed [POS_WIDTH-1:0] s0_target_reg;
    logic [SPEED_W-1:0]          s0_speed_reg;
    logic signed [POS_WIDTH-1:0] s0_left_reg;
    logic signed [POS_WIDTH-1:0] s0_right_reg;

    // loop state
    logic signed [POS_WIDTH-1:0]   target_reg;
    logic [SPEED_W-1:0]            speed_reg;
    logic signed [ERR_W-1:0]       prev_err_reg;
    logic signed [INTEG_WIDTH-1:0] integ_reg;
    phase_t                        phase_reg;

    // stage 1 register
    logic                          s1_valid_reg;
    ctl_t                          s1_ctl_reg;
    logic signed [ERR_W-1:0]       s1_err_reg;
    logic signed [DER_W-1:0]       s1_deriv_reg;
    logic signed [INTEG_WIDTH-1:0] s1_integ_reg;
    logic [GAIN_W-1:0]             s1_kp_reg;
    logic [GAIN_W-1:0]             s1_ki_reg;
    logic [GAIN_W-1:0]             s1_kd_reg;

    logic                          s1_free;
    logic                          s1_load;
    logic                          is_start;
    logic signed [ERR_W-1:0]       tgt2;
    logic signed [ERR_W-1:0]       pos_diff;
    logic signed [ERR_W-1:0]       err;
    logic signed [DER_W-1:0]       deriv;
    logic signed [SAT_W-1:0]       isum;
    logic signed [INTEG_WIDTH-1:0] integ_next;
    logic [ERR_W-1:0]              err_mag;
    logic [ERR_W-1:0]              tgt2_mag;
    logic [CMP_W-1:0]              err_scaled;
    logic [CMP_W-1:0]              thresh;
    phase_t                        phase_next;
    logic                          done;
    logic [GAIN_W-1:0]             kp;
    logic [GAIN_W-1:0]             ki;
    logic [GAIN_W-1:0]             kd;

    assign s1_free   = !s1_valid_reg || s1_ready;
    assign s1_load   = s0_valid_reg && s1_free;
    assign req.ready = !s0_valid_reg || s1_free;
    assign is_start  = (s0_cmd_reg == CMD_START);

    always_comb
    begin
        // error in half-lsb: 2*target - (left - right)
        tgt2     = ERR_W'(target_reg) <<< 1;
        pos_diff = ERR_W'(s0_left_reg) - ERR_W'(s0_right_reg);
        err      = tgt2 - pos_diff;
        deriv    = DER_W'(err) - DER_W'(prev_err_reg);

        // saturating integrator
        isum = SAT_W'(integ_reg) + SAT_W'(err);
        if (isum > IMAX)
            integ_next = INTEG_WIDTH'(IMAX);
        else if (isum < IMIN)
            integ_next = INTEG_WIDTH'(IMIN);
        else
            integ_next = INTEG_WIDTH'(isum);

        // gain scheduling: accel while |e|*256 > frac*|2*target|
        err_mag    = err[ERR_W-1] ? -err : err;
        tgt2_mag   = tgt2[ERR_W-1] ? -tgt2 : tgt2;
        err_scaled = {err_mag, FRAC_W'(0)};
        thresh     = CMP_W'(tgt2_mag) * CMP_W'(cfg.accel_fraction);
        phase_next = (err_scaled > thresh) ? PH_ACCEL : PH_TRACK;
        done       = (err_mag <= ERR_W'(cfg.settle_band));

        case (phase_reg)
            PH_INIT:
            begin
                kp = cfg.init_kp;
                ki = cfg.init_ki;
                kd = cfg.init_kd;
            end
            PH_ACCEL:
            begin
                kp = '0;
                ki = cfg.accel_ki;
                kd = '0;
            end
            default:
            begin
                kp = cfg.track_kp;
                ki = '0;
                kd = cfg.track_kd;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            target_reg   <= '0;
            speed_reg    <= '0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            phase_reg    <= PH_INIT;
        end
        else
        begin
            if (req.ready)
                s0_valid_reg <= req.valid;
            if (s1_free)
                s1_valid_reg <= s0_valid_reg;
            if (s1_load)
            begin
                if (is_start)
                begin
                    target_reg   <= s0_target_reg;
                    speed_reg    <= s0_speed_reg;
                    prev_err_reg <= '0;
                    integ_reg    <= '0;
                    phase_reg    <= PH_INIT;
                end
                else
                begin
                    prev_err_reg <= err;
                    integ_reg    <= integ_next;
                    phase_reg    <= phase_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s0_cmd_reg    <= req.cmd;
            s0_target_reg <= req.target;
            s0_speed_reg  <= req.speed_limit;
            s0_left_reg   <= req.left_position;
            s0_right_reg  <= req.right_position;
        end
        if (s1_load)
        begin
            s1_ctl_reg.start <= is_start;
            s1_ctl_reg.speed <= speed_reg;
            s1_ctl_reg.done  <= done && !is_start;
            s1_ctl_reg.phase <= is_start ? PH_INIT : phase_next;
            s1_err_reg       <= err;
            s1_deriv_reg     <= deriv;
            s1_integ_reg     <= integ_next;
            s1_kp_reg        <= kp;
            s1_ki_reg        <= ki;
            s1_kd_reg        <= kd;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_err   = s1_err_reg;
    assign s1_deriv = s1_deriv_reg;
    assign s1_integ = s1_integ_reg;
    assign s1_kp    = s1_kp_reg;
    assign s1_ki    = s1_ki_reg;
    assign s1_kd    = s1_kd_reg;

endmodule

@@ hdl/gspd_mul.sv @@
`timescale 1ns / 1ps

module gspd_mul #(
    parameter int POS_WIDTH   = 32,
    parameter int INTEG_WIDTH = 48
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  gspd_pkg::ctl_t                              in_ctl,
    input  logic signed [POS_WIDTH+1:0]                 in_err,
    input  logic signed [POS_WIDTH+2:0]                 in_deriv,
    input  logic signed [INTEG_WIDTH-1:0]               in_integ,
    input  logic [gspd_pkg::GAIN_W-1:0]                 in_kp,
    input  logic [gspd_pkg::GAIN_W-1:0]                 in_ki,
    input  logic [gspd_pkg::GAIN_W-1:0]                 in_kd,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output gspd_pkg::ctl_t                              out_ctl,
    output logic signed [POS_WIDTH+gspd_pkg::GAIN_W+2:0] out_p_err,
    output logic signed [POS_WIDTH+gspd_pkg::GAIN_W+3:0] out_p_der,
    output logic signed [INTEG_WIDTH+gspd_pkg::GAIN_W:0] out_p_int
);
    import gspd_pkg::*;

    localparam int PE_W = POS_WIDTH + 2 + GAIN_W + 1;
    localparam int PD_W = POS_WIDTH + 3 + GAIN_W + 1;
    localparam int PI_W = INTEG_WIDTH + GAIN_W + 1;

    logic                   valid_reg;
    ctl_t                   ctl_reg;
    logic signed [PE_W-1:0] p_err_reg;
    logic signed [PD_W-1:0] p_der_reg;
    logic signed [PI_W-1:0] p_int_reg;

    logic signed [GAIN_W:0] kp_s;
    logic signed [GAIN_W:0] ki_s;
    logic signed [GAIN_W:0] kd_s;
    logic                   load;

    // gains are unsigned: zero-extend into signed operands
    assign kp_s     = {1'b0, in_kp};
    assign ki_s     = {1'b0, in_ki};
    assign kd_s     = {1'b0, in_kd};
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg   <= in_ctl;
            p_err_reg <= PE_W'(in_err) * PE_W'(kp_s);
            p_der_reg <= PD_W'(in_deriv) * PD_W'(kd_s);
            p_int_reg <= PI_W'(in_integ) * PI_W'(ki_s);
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_p_err = p_err_reg;
    assign out_p_der = p_der_reg;
    assign out_p_int = p_int_reg;

endmodule

@@ hdl/gspd_vel_out.sv @@
`timescale 1ns / 1ps

module gspd_vel_out #(
    parameter int POS_WIDTH   = 32,
    parameter int INTEG_WIDTH = 48
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  gspd_pkg::ctl_t                              in_ctl,
    input  logic signed [POS_WIDTH+gspd_pkg::GAIN_W+2:0] in_p_err,
    input  logic signed [POS_WIDTH+gspd_pkg::GAIN_W+3:0] in_p_der,
    input  logic signed [INTEG_WIDTH+gspd_pkg::GAIN_W:0] in_p_int,
    gspd_rsp_if.source                                  rsp
);
    import gspd_pkg::*;

    localparam int PD_W  = POS_WIDTH + 3 + GAIN_W + 1;
    localparam int PI_W  = INTEG_WIDTH + GAIN_W + 1;
    localparam int SUM_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
    localparam int HI_W  = SUM_W - QSHIFT;

    logic                    valid_reg;
    logic signed [VEL_W-1:0] vel_reg;
    logic                    done_reg;
    logic [PHASE_W-1:0]      phase_reg;

    logic signed [SUM_W-1:0] sum;
    logic                    neg;
    logic [SUM_W-1:0]        mag;
    logic [HI_W-1:0]         hi;
    logic [VEL_W-1:0]        q;
    logic [VEL_W-1:0]        vmag;
    logic signed [VEL_W-1:0] vel;

    assign in_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        sum = SUM_W'(in_p_err) + SUM_W'(in_p_der) + SUM_W'(in_p_int);
        neg = sum[SUM_W-1];
        mag = neg ? -sum : sum;
        // truncate toward zero, saturate at one past the largest speed
        hi  = mag[SUM_W-1:QSHIFT];
        q   = (hi > HI_W'(QSAT)) ? VEL_W'(QSAT) : VEL_W'(hi);
        vmag = (q > VEL_W'(in_ctl.speed)) ? VEL_W'(in_ctl.speed) : q;
        // dead zone: nonzero commands get at least DEAD_ZONE
        if ((vmag != '0) && (vmag < VEL_W'(DEAD_ZONE)))
            vmag = VEL_W'(DEAD_ZONE);
        vel = neg ? -vmag : vmag;
        if (in_ctl.start)
            vel = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vel_reg   <= vel;
            done_reg  <= in_ctl.done;
            phase_reg <= in_ctl.phase;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.drive_velocity = vel_reg;
    assign rsp.done_res       = done_reg;
    assign rsp.phase          = phase_reg;

endmodule

@@ hdl/gain_scheduled_pid_drive.sv @@
`timescale 1ns / 1ps
// channel | dir | handshake      | word
// --------+-----+----------------+-------------------------------------------------
// req     | in  | valid/ready    | cmd, target, speed_limit, left/right_position
// rsp     | out | valid/ready    | drive_velocity, done_res, phase
// apb     | in  | psel/penable   | 8 config regs at 4*i, pready tied high
//
// One word per clock sustained while rsp is ready; accept loads the input
// reg, and each word then passes through the loop-state, gain multiply and
// output regs in that order.
// The integrator / previous-error / phase recurrence closes within the
// loop-state stage, so back-to-back samples need no bypass.
// Each stage has its own valid bit; a stalled rsp fills empty stages first.
// Reset clears all valid bits and the loop state; config regs take defaults.

module gain_scheduled_pid_drive #(
    parameter int POS_WIDTH   = 32,
    parameter int INTEG_WIDTH = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gspd_pkg::ADDR_W-1:0] paddr,
    input  logic [gspd_pkg::DATA_W-1:0] pwdata,
    output logic [gspd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    gspd_req_if.sink                    req,
    gspd_rsp_if.source                  rsp
);
    import gspd_pkg::*;

    localparam int ERR_W = POS_WIDTH + 2;
    localparam int DER_W = POS_WIDTH + 3;
    localparam int PE_W  = ERR_W + GAIN_W + 1;
    localparam int PD_W  = DER_W + GAIN_W + 1;
    localparam int PI_W  = INTEG_WIDTH + GAIN_W + 1;

    cfg_t cfg;

    // loop-state stage -> multiply stage
    logic                          s1_valid;
    logic                          s1_ready;
    ctl_t                          s1_ctl;
    logic signed [ERR_W-1:0]       s1_err;
    logic signed [DER_W-1:0]       s1_deriv;
    logic signed [INTEG_WIDTH-1:0] s1_integ;
    logic [GAIN_W-1:0]             s1_kp;
    logic [GAIN_W-1:0]             s1_ki;
    logic [GAIN_W-1:0]             s1_kd;

    // multiply stage -> output stage
    logic                   s2_valid;
    logic                   s2_ready;
    ctl_t                   s2_ctl;
    logic signed [PE_W-1:0] s2_p_err;
    logic signed [PD_W-1:0] s2_p_der;
    logic signed [PI_W-1:0] s2_p_int;

    gspd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // error, derivative, saturating integrator and gain schedule
    gspd_loop #(
        .POS_WIDTH   (POS_WIDTH),
        .INTEG_WIDTH (INTEG_WIDTH)
    ) u_loop (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req      (req),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_ctl   (s1_ctl),
        .s1_err   (s1_err),
        .s1_deriv (s1_deriv),
        .s1_integ (s1_integ),
        .s1_kp    (s1_kp),
        .s1_ki    (s1_ki),
        .s1_kd    (s1_kd)
    );

    // three independent gain products
    gspd_mul #(
        .POS_WIDTH   (POS_WIDTH),
        .INTEG_WIDTH (INTEG_WIDTH)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_ctl    (s1_ctl),
        .in_err    (s1_err),
        .in_deriv  (s1_deriv),
        .in_integ  (s1_integ),
        .in_kp     (s1_kp),
        .in_ki     (s1_ki),
        .in_kd     (s1_kd),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_ctl   (s2_ctl),
        .out_p_err (s2_p_err),
        .out_p_der (s2_p_der),
        .out_p_int (s2_p_int)
    );

    // sum, scale, speed clamp, dead zone, result register
    gspd_vel_out #(
        .POS_WIDTH   (POS_WIDTH),
        .INTEG_WIDTH (INTEG_WIDTH)
    ) u_vel (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid),
        .in_ready (s2_ready),
        .in_ctl   (s2_ctl),
        .in_p_err (s2_p_err),
        .in_p_der (s2_p_der),
        .in_p_int (s2_p_int),
        .rsp      (rsp)
    );

endmodule
